### src/wpf_pkg.sv
// Shared constants, codes and types for the waypoint PI position follower.
package wpf_pkg;

   localparam int MAX_WAYPOINTS_DEF = 16;

   localparam int SLOT_W     = 4;
   localparam int CELL_W     = 4;
   localparam int ENTRY_W    = 2 * CELL_W;
   localparam int POS_W      = 16;
   localparam int TIME_W     = 32;
   localparam int GAIN_W     = 16;
   localparam int DWELL_W    = 16;
   localparam int BYTE_W     = 8;
   localparam int PLEN_W     = 5;
   localparam int TGT_W      = 13;
   localparam int TGT_OUT_W  = 16;
   localparam int ERR_W      = 18;
   localparam int INTEG_W    = 9;
   localparam int SPEED_W    = 32;
   localparam int WAYNOW_W   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CMP_W      = 9;

   localparam int NEAR_LIMIT  = 10;
   localparam int INTEG_LIMIT = 200;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KP          = 3'd0,
      REG_KI          = 3'd1,
      REG_DWELL       = 3'd2,
      REG_CELL_SIZE   = 3'd3,
      REG_ORIGIN_X    = 3'd4,
      REG_ORIGIN_Y    = 3'd5,
      REG_HOME_OFFSET = 3'd6,
      REG_PATH_LENGTH = 3'd7
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TICK = 1'b1
   } command_type;

   localparam logic signed [GAIN_W-1:0] KP_RESET          = 16'sd1434;
   localparam logic signed [GAIN_W-1:0] KI_RESET          = -16'sd20;
   localparam logic [DWELL_W-1:0]       DWELL_RESET       = 16'd100;
   localparam logic [BYTE_W-1:0]        CELL_SIZE_RESET   = 8'd80;
   localparam logic [BYTE_W-1:0]        ORIGIN_X_RESET    = 8'd10;
   localparam logic [BYTE_W-1:0]        ORIGIN_Y_RESET    = 8'd11;
   localparam logic [BYTE_W-1:0]        HOME_OFFSET_RESET = 8'd32;
   localparam logic [PLEN_W-1:0]        PATH_LENGTH_RESET = 5'd13;

   // per-axis result of the update stage
   typedef struct packed {
      logic signed [ERR_W-1:0]   err;
      logic                      near;
      logic signed [INTEG_W-1:0] integ;
      logic [TGT_W-1:0]          target;
   } axis_type;

endpackage

### src/wpf_channels.sv
// Request and response channel interfaces of the waypoint follower.
interface wpf_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [wpf_pkg::SLOT_W-1:0]          slot;
   logic [wpf_pkg::CELL_W-1:0]          grid_x;
   logic [wpf_pkg::CELL_W-1:0]          grid_y;
   logic signed [wpf_pkg::POS_W-1:0]    pos_x;
   logic signed [wpf_pkg::POS_W-1:0]    pos_y;
   logic [wpf_pkg::TIME_W-1:0]          time_ms;

   modport source (output valid, command, slot, grid_x, grid_y, pos_x, pos_y, time_ms,
                   input ready);
   modport sink (input valid, command, slot, grid_x, grid_y, pos_x, pos_y, time_ms,
                 output ready);
endinterface

interface wpf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [wpf_pkg::SPEED_W-1:0]  speed_x;
   logic signed [wpf_pkg::SPEED_W-1:0]  speed_y;
   logic [wpf_pkg::TGT_OUT_W-1:0]       target_x;
   logic [wpf_pkg::TGT_OUT_W-1:0]       target_y;
   logic [wpf_pkg::WAYNOW_W-1:0]        waypoint_now;
   logic                                arrived;
   logic                                land_request;
   logic                                done_res;

   modport source (output valid, speed_x, speed_y, target_x, target_y, waypoint_now,
                   arrived, land_request, done_res, input ready);
   modport sink (input valid, speed_x, speed_y, target_x, target_y, waypoint_now,
                 arrived, land_request, done_res, output ready);
endinterface

### src/waypoint_pi_position_follower_top.sv
// Waypoint PI position follower: path table, dwell tracking and PI speed output.
// Pipeline: an accepted transaction passes the update-stage register, then the result register.
// Throughput: one transaction per cycle while results are taken; the waypoint table is read
//   every cycle at the next path index, so back-to-back ticks and loads never wait on the memory.
// Reset (synchronous, active high): path index, integrals, dwell time, done flag,
//   pipeline valids and registers go to their defaults; the table stays as written.
module waypoint_pi_position_follower_top #(
   parameter int MAX_WAYPOINTS = wpf_pkg::MAX_WAYPOINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   wpf_req_if.sink                           req_ch,
   wpf_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [wpf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wpf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W     = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int CMP_W     = wpf_pkg::CMP_W;
   localparam int ENTRY_W   = wpf_pkg::ENTRY_W;
   localparam int CELL_W    = wpf_pkg::CELL_W;
   localparam int ERR_W     = wpf_pkg::ERR_W;
   localparam int INTEG_W   = wpf_pkg::INTEG_W;
   localparam int GAIN_W    = wpf_pkg::GAIN_W;
   localparam int SPEED_W   = wpf_pkg::SPEED_W;
   localparam int TIME_W    = wpf_pkg::TIME_W;
   localparam int TGT_W     = wpf_pkg::TGT_W;
   localparam int TGT_OUT_W = wpf_pkg::TGT_OUT_W;
   localparam int WAYNOW_W  = wpf_pkg::WAYNOW_W;
   localparam int BYTE_W    = wpf_pkg::BYTE_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_WAYPOINTS);

   // update stage -> multiply stage
   typedef struct packed {
      logic signed [ERR_W-1:0]   err_x;
      logic signed [ERR_W-1:0]   err_y;
      logic signed [INTEG_W-1:0] integ_x;
      logic signed [INTEG_W-1:0] integ_y;
      logic                      zero_speed;
      logic [TGT_W-1:0]          target_x;
      logic [TGT_W-1:0]          target_y;
      logic [WAYNOW_W-1:0]       waypoint_now;
      logic                      arrived;
      logic                      land;
      logic                      done;
   } stage_type;

   // ---------------- configuration registers ----------------
   logic signed [GAIN_W-1:0]            kp_ff;
   logic signed [GAIN_W-1:0]            ki_ff;
   logic [wpf_pkg::DWELL_W-1:0]         dwell_ff;
   logic [BYTE_W-1:0]                   cell_size_ff;
   logic [BYTE_W-1:0]                   origin_x_ff;
   logic [BYTE_W-1:0]                   origin_y_ff;
   logic [BYTE_W-1:0]                   home_offset_ff;
   logic [wpf_pkg::PLEN_W-1:0]          path_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff          <= wpf_pkg::KP_RESET;
         ki_ff          <= wpf_pkg::KI_RESET;
         dwell_ff       <= wpf_pkg::DWELL_RESET;
         cell_size_ff   <= wpf_pkg::CELL_SIZE_RESET;
         origin_x_ff    <= wpf_pkg::ORIGIN_X_RESET;
         origin_y_ff    <= wpf_pkg::ORIGIN_Y_RESET;
         home_offset_ff <= wpf_pkg::HOME_OFFSET_RESET;
         path_length_ff <= wpf_pkg::PATH_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (wpf_pkg::csr_index_type'(csr_index))
            wpf_pkg::REG_KP:          kp_ff          <= csr_wdata;
            wpf_pkg::REG_KI:          ki_ff          <= csr_wdata;
            wpf_pkg::REG_DWELL:       dwell_ff       <= csr_wdata;
            wpf_pkg::REG_CELL_SIZE:   cell_size_ff   <= csr_wdata[BYTE_W-1:0];
            wpf_pkg::REG_ORIGIN_X:    origin_x_ff    <= csr_wdata[BYTE_W-1:0];
            wpf_pkg::REG_ORIGIN_Y:    origin_y_ff    <= csr_wdata[BYTE_W-1:0];
            wpf_pkg::REG_HOME_OFFSET: home_offset_ff <= csr_wdata[BYTE_W-1:0];
            wpf_pkg::REG_PATH_LENGTH: path_length_ff <= csr_wdata[wpf_pkg::PLEN_W-1:0];
         endcase
      end
   end

   // ---------------- handshake and pipeline enables ----------------
   logic      s1_valid_ff;
   logic      rsp_valid_ff;
   logic      s2_en;
   logic      s1_en;
   logic      accept;

   // result register frees when empty or taken; update stage frees into it
   assign s2_en        = !rsp_valid_ff || rsp_ch.ready;
   assign s1_en        = !s1_valid_ff || s2_en;
   assign req_ch.ready = !reset && s1_en;
   assign accept       = req_ch.valid && req_ch.ready;

   // ---------------- follower state ----------------
   logic [IDX_W-1:0]          path_index_ff, path_index_in;
   logic signed [INTEG_W-1:0] integ_x_ff, integ_x_in;
   logic signed [INTEG_W-1:0] integ_y_ff, integ_y_in;
   logic [TIME_W-1:0]         near_since_ff, near_since_in;
   logic                      done_ff, done_in;

   // ---------------- waypoint table ----------------
   // entry_ff always holds table[path_index_ff], including the write of the
   // previous cycle (write-through on the read port).
   logic [ENTRY_W-1:0] table_mem [MAX_WAYPOINTS];
   logic [ENTRY_W-1:0] entry_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               wr_en;

   assign wr_addr = IDX_W'(req_ch.slot);
   assign wr_data = {req_ch.grid_y, req_ch.grid_x};
   // slots past the table are dropped
   assign wr_en   = accept && (req_ch.command == wpf_pkg::CMD_LOAD)
                    && (CMP_W'(req_ch.slot) < MAX_CMP);
   assign rd_addr = reset ? '0 : path_index_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         entry_ff <= wr_data;
      end else begin
         entry_ff <= table_mem[rd_addr];
      end
   end

   // ---------------- update stage ----------------
   logic [ENTRY_W-1:0]   entry_cur;
   logic                 home;
   logic                 run;
   logic                 both_near;
   logic [TIME_W-1:0]    elapsed;
   logic                 arrive;
   logic                 last;
   logic                 land;
   logic [CMP_W-1:0]     plen;
   logic [CMP_W-1:0]     eff_len;
   wpf_pkg::axis_type    ax;
   wpf_pkg::axis_type    ay;
   stage_type            s1_in;
   stage_type            s1_ff;

   // a load into the slot being pursued is seen by its own result
   assign entry_cur = (wr_en && (wr_addr == path_index_ff)) ? wr_data : entry_ff;
   assign home      = (entry_cur == '0);

   wpf_axis_upd u_axis_x (
      .cell_idx    (entry_cur[CELL_W-1:0]),
      .home        (home),
      .origin      (origin_x_ff),
      .home_offset (home_offset_ff),
      .cell_size   (cell_size_ff),
      .pos         (req_ch.pos_x),
      .integ       (integ_x_ff),
      .res         (ax)
   );

   wpf_axis_upd u_axis_y (
      .cell_idx    (entry_cur[ENTRY_W-1:CELL_W]),
      .home        (home),
      .origin      (origin_y_ff),
      .home_offset (home_offset_ff),
      .cell_size   (cell_size_ff),
      .pos         (req_ch.pos_y),
      .integ       (integ_y_ff),
      .res         (ay)
   );

   always_comb begin
      run       = accept && (req_ch.command == wpf_pkg::CMD_TICK) && !done_ff;
      both_near = ax.near && ay.near;
      elapsed   = req_ch.time_ms - near_since_ff;
      arrive    = run && both_near && (elapsed > TIME_W'(dwell_ff));

      // path length saturates into 1..MAX_WAYPOINTS
      plen = CMP_W'(path_length_ff);
      priority if (plen == '0) begin
         eff_len = CMP_W'(1);
      end else if (plen > MAX_CMP) begin
         eff_len = MAX_CMP;
      end else begin
         eff_len = plen;
      end
      last = (CMP_W'(path_index_ff) + CMP_W'(1)) >= eff_len;
      land = arrive && last;

      path_index_in = path_index_ff;
      if (arrive) begin
         path_index_in = last ? '0 : path_index_ff + IDX_W'(1);
      end
      done_in       = done_ff || land;
      integ_x_in    = run ? ax.integ : integ_x_ff;
      integ_y_in    = run ? ay.integ : integ_y_ff;
      near_since_in = (run && !both_near) ? req_ch.time_ms : near_since_ff;

      s1_in.err_x        = ax.err;
      s1_in.err_y        = ay.err;
      s1_in.integ_x      = ax.integ;
      s1_in.integ_y      = ay.integ;
      s1_in.zero_speed   = !run || land;
      s1_in.target_x     = ax.target;
      s1_in.target_y     = ay.target;
      s1_in.waypoint_now = WAYNOW_W'(path_index_in);
      s1_in.arrived      = arrive;
      s1_in.land         = land;
      s1_in.done         = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         path_index_ff <= '0;
         integ_x_ff    <= '0;
         integ_y_ff    <= '0;
         near_since_ff <= '0;
         done_ff       <= 1'b0;
         s1_valid_ff   <= 1'b0;
      end else begin
         path_index_ff <= path_index_in;
         integ_x_ff    <= integ_x_in;
         integ_y_ff    <= integ_y_in;
         near_since_ff <= near_since_in;
         done_ff       <= done_in;
         if (s1_en) begin
            s1_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------- multiply stage / result register ----------------
   // speed = err*kp + integ*ki, exact in Q10; low 32 bits kept
   logic signed [ERR_W+GAIN_W-1:0]   kp_prod_x, kp_prod_y;
   logic signed [INTEG_W+GAIN_W-1:0] ki_prod_x, ki_prod_y;
   logic signed [SPEED_W-1:0]        speed_x_in, speed_y_in;
   logic signed [SPEED_W-1:0]        speed_x_ff, speed_y_ff;
   logic [TGT_OUT_W-1:0]             target_x_ff, target_y_ff;
   logic [WAYNOW_W-1:0]              waypoint_now_ff;
   logic                             arrived_ff, land_ff, done_res_ff;

   always_comb begin
      kp_prod_x = s1_ff.err_x * kp_ff;
      kp_prod_y = s1_ff.err_y * kp_ff;
      ki_prod_x = s1_ff.integ_x * ki_ff;
      ki_prod_y = s1_ff.integ_y * ki_ff;
      if (s1_ff.zero_speed) begin
         speed_x_in = '0;
         speed_y_in = '0;
      end else begin
         speed_x_in = SPEED_W'(kp_prod_x) + SPEED_W'(ki_prod_x);
         speed_y_in = SPEED_W'(kp_prod_y) + SPEED_W'(ki_prod_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         speed_x_ff      <= speed_x_in;
         speed_y_ff      <= speed_y_in;
         target_x_ff     <= TGT_OUT_W'(s1_ff.target_x);
         target_y_ff     <= TGT_OUT_W'(s1_ff.target_y);
         waypoint_now_ff <= s1_ff.waypoint_now;
         arrived_ff      <= s1_ff.arrived;
         land_ff         <= s1_ff.land;
         done_res_ff     <= s1_ff.done;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.speed_x      = speed_x_ff;
   assign rsp_ch.speed_y      = speed_y_ff;
   assign rsp_ch.target_x     = target_x_ff;
   assign rsp_ch.target_y     = target_y_ff;
   assign rsp_ch.waypoint_now = waypoint_now_ff;
   assign rsp_ch.arrived      = arrived_ff;
   assign rsp_ch.land_request = land_ff;
   assign rsp_ch.done_res     = done_res_ff;

endmodule

### src/wpf_axis_upd.sv
// One axis: grid cell to target, position error, near test and integral update.
module wpf_axis_upd (
   input  logic [wpf_pkg::CELL_W-1:0]        cell_idx,
   input  logic                              home,
   input  logic [wpf_pkg::BYTE_W-1:0]        origin,
   input  logic [wpf_pkg::BYTE_W-1:0]        home_offset,
   input  logic [wpf_pkg::BYTE_W-1:0]        cell_size,
   input  logic signed [wpf_pkg::POS_W-1:0]  pos,
   input  logic signed [wpf_pkg::INTEG_W-1:0] integ,
   output wpf_pkg::axis_type                 res
);

   localparam int TGT_W   = wpf_pkg::TGT_W;
   localparam int ERR_W   = wpf_pkg::ERR_W;
   localparam int INTEG_W = wpf_pkg::INTEG_W;
   localparam int SUM_W   = INTEG_W + 1;

   localparam logic signed [ERR_W-1:0] NEAR_HI  = ERR_W'(wpf_pkg::NEAR_LIMIT);
   localparam logic signed [ERR_W-1:0] NEAR_LO  = ERR_W'(-wpf_pkg::NEAR_LIMIT);
   localparam logic signed [SUM_W-1:0] CLAMP_HI = SUM_W'(wpf_pkg::INTEG_LIMIT);
   localparam logic signed [SUM_W-1:0] CLAMP_LO = SUM_W'(-wpf_pkg::INTEG_LIMIT);

   logic [TGT_W-1:0]        span;
   logic [TGT_W-1:0]        target;
   logic signed [ERR_W-1:0] err;
   logic                    near;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] clamped;

   always_comb begin
      span = TGT_W'(cell_idx) * TGT_W'(cell_size);
      if (home) begin
         target = TGT_W'(origin) + TGT_W'(home_offset);
      end else begin
         target = TGT_W'(origin) + TGT_W'(cell_size >> 1) + span;
      end
      err  = $signed(ERR_W'(target)) - ERR_W'(pos);
      near = (err > NEAR_LO) && (err < NEAR_HI);
      // error is within +/-9 when it accumulates, so 10 bits hold the sum
      sum  = SUM_W'(integ) + SUM_W'(err);
      priority if (!near) begin
         clamped = '0;
      end else if (sum > CLAMP_HI) begin
         clamped = CLAMP_HI;
      end else if (sum < CLAMP_LO) begin
         clamped = CLAMP_LO;
      end else begin
         clamped = sum;
      end
      res.err    = err;
      res.near   = near;
      res.integ  = INTEG_W'(clamped);
      res.target = target;
   end

endmodule

### src/wpf_checker.sv
// Port-level checks for the waypoint follower, bound to the top level.
module wpf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [wpf_pkg::SPEED_W-1:0] speed_x,
   input logic signed [wpf_pkg::SPEED_W-1:0] speed_y,
   input logic                              arrived,
   input logic                              land_request,
   input logic                              done_res
);

   logic seen_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_done_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && done_res) begin
         seen_done_ff <= 1'b1;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(speed_x) && $stable(speed_y)
      && $stable(done_res))
      else $error("stalled result changed");

   a_land: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && land_request |-> arrived && done_res && speed_x == '0 && speed_y == '0)
      else $error("land transaction inconsistent");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res && !land_request |-> !arrived && speed_x == '0 && speed_y == '0)
      else $error("motion after path done");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_done_ff |-> done_res)
      else $error("done flag cleared");

endmodule

bind waypoint_pi_position_follower_top wpf_checker u_wpf_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .speed_x      (rsp_ch.speed_x),
   .speed_y      (rsp_ch.speed_y),
   .arrived      (rsp_ch.arrived),
   .land_request (rsp_ch.land_request),
   .done_res     (rsp_ch.done_res)
);

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the waypoint PI position follower: predictor, stimulus and checks.
module testbench;
   import wpf_pkg::*;

   // Generous ceiling: roughly 700 transactions, drains included.
   localparam int CYCLE_LIMIT   = 200000;
   // Spare cycles after the queue empties, before a CSR write.
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_LIMIT  = 10;

   // One request transaction as seen on the req channel.
   typedef struct packed {
      command_type               command;
      logic [SLOT_W-1:0]         slot;
      logic [CELL_W-1:0]         grid_x;
      logic [CELL_W-1:0]         grid_y;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic [TIME_W-1:0]         time_ms;
   } follow_req_type;

   // One response transaction: speed command plus path status.
   typedef struct packed {
      logic signed [SPEED_W-1:0] speed_x;
      logic signed [SPEED_W-1:0] speed_y;
      logic [TGT_OUT_W-1:0]      target_x;
      logic [TGT_OUT_W-1:0]      target_y;
      logic [WAYNOW_W-1:0]       waypoint_now;
      logic                      arrived;
      logic                      land_request;
      logic                      done_res;
   } follow_rsp_type;

   // Tracks the follower's state, predicts each speed command and checks the responses.
   class follower_scoreboard;
      logic signed [GAIN_W-1:0] kp, ki;
      logic [DWELL_W-1:0]       dwell;
      logic [BYTE_W-1:0]        cell_sz, org_x, org_y, home_ofs;
      logic [PLEN_W-1:0]        plen;
      logic [ENTRY_W-1:0]       wp_table [MAX_WAYPOINTS_DEF];
      logic [WAYNOW_W-1:0]      leg;
      int                       integ_x, integ_y;
      logic [TIME_W-1:0]        settle_start;
      bit                       finished;
      follow_rsp_type           expected_cmds [$];
      int                       fail_count;

      function new();
         kp = KP_RESET;
         ki = KI_RESET;
         dwell = DWELL_RESET;
         cell_sz = CELL_SIZE_RESET;
         org_x = ORIGIN_X_RESET;
         org_y = ORIGIN_Y_RESET;
         home_ofs = HOME_OFFSET_RESET;
         plen = PATH_LENGTH_RESET;
         leg = '0;
         integ_x = 0;
         integ_y = 0;
         settle_start = '0;
         finished = 1'b0;
         fail_count = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            REG_KP:          kp = v;
            REG_KI:          ki = v;
            REG_DWELL:       dwell = v;
            REG_CELL_SIZE:   cell_sz = v[BYTE_W-1:0];
            REG_ORIGIN_X:    org_x = v[BYTE_W-1:0];
            REG_ORIGIN_Y:    org_y = v[BYTE_W-1:0];
            REG_HOME_OFFSET: home_ofs = v[BYTE_W-1:0];
            REG_PATH_LENGTH: plen = v[PLEN_W-1:0];
            default: ;
         endcase
      endfunction

      // path length as actually used: saturated into 1..MAX
      function int eff_len();
         int n;
         n = int'(plen);
         if (n < 1) n = 1;
         if (n > MAX_WAYPOINTS_DEF) n = MAX_WAYPOINTS_DEF;
         return n;
      endfunction

      function int aim(logic [CELL_W-1:0] g, logic [BYTE_W-1:0] org, bit at_home);
         if (at_home) return int'(org) + int'(home_ofs);
         return int'(org) + int'(cell_sz >> 1) + int'(g) * int'(cell_sz);
      endfunction

      // target of the waypoint being pursued; cell (0,0) is the home point
      function void aim_now(output int tx, output int ty);
         logic [ENTRY_W-1:0] e;
         e = wp_table[leg];
         tx = aim(e[CELL_W-1:0], org_x, e == '0);
         ty = aim(e[ENTRY_W-1:CELL_W], org_y, e == '0);
      endfunction

      function int axis_pi(int err, inout int integ, output bit near);
         near = (err > -NEAR_LIMIT) && (err < NEAR_LIMIT);
         integ = near ? integ + err : 0;
         if (integ > INTEG_LIMIT) integ = INTEG_LIMIT;
         if (integ < -INTEG_LIMIT) integ = -INTEG_LIMIT;
         return err * int'(kp) + integ * int'(ki);
      endfunction

      function void note_request(follow_req_type r);
         follow_rsp_type e;
         int tx, ty, sx, sy;
         bit nx, ny;
         logic [TIME_W-1:0] held;
         e = '0;
         sx = 0;
         sy = 0;
         if (r.command == CMD_LOAD) wp_table[r.slot] = {r.grid_y, r.grid_x};
         aim_now(tx, ty);
         if (r.command == CMD_TICK && !finished) begin
            sx = axis_pi(tx - int'(r.pos_x), integ_x, nx);
            sy = axis_pi(ty - int'(r.pos_y), integ_y, ny);
            held = r.time_ms - settle_start;
            if (!(nx && ny)) begin
               settle_start = r.time_ms;
            end else if (held > TIME_W'(dwell)) begin
               e.arrived = 1'b1;
               if (int'(leg) + 1 < eff_len()) begin
                  leg++;
               end else begin
                  finished = 1'b1;
                  e.land_request = 1'b1;
                  leg = '0;
                  sx = 0;
                  sy = 0;
               end
            end
         end
         e.speed_x = sx;
         e.speed_y = sy;
         e.target_x = tx[TGT_OUT_W-1:0];
         e.target_y = ty[TGT_OUT_W-1:0];
         e.waypoint_now = leg;
         e.done_res = finished;
         expected_cmds.push_back(e);
      endfunction

      function string describe(follow_rsp_type c);
         return $sformatf("sx=%0d sy=%0d tx=%0d ty=%0d wp=%0d arr=%0b land=%0b done=%0b",
                          c.speed_x, c.speed_y, c.target_x, c.target_y, c.waypoint_now,
                          c.arrived, c.land_request, c.done_res);
      endfunction

      function void check_command(follow_rsp_type got);
         follow_rsp_type want;
         if (expected_cmds.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected command transaction: %s", describe(got));
            return;
         end
         want = expected_cmds.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("command mismatch, expected %s", describe(want));
               $display("                  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wpf_req_if req_bus ();
   wpf_rsp_if rsp_bus ();

   follower_scoreboard sb;

   int send_idle_pct;   // chance per cycle that the sender holds off
   int recv_idle_pct;   // chance per cycle that the receiver stalls
   bit last_phase;      // path completion is allowed only in the closing phase
   int run_left;        // transactions left in the current near-target run
   int bias_lo, bias_hi;

   waypoint_pi_position_follower_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: ready is redrawn at every falling edge.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Response monitor: sample at the rising edge, compare against the oldest prediction.
   always @(posedge clock) begin
      follow_rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.speed_x = rsp_bus.speed_x;
         got.speed_y = rsp_bus.speed_y;
         got.target_x = rsp_bus.target_x;
         got.target_y = rsp_bus.target_y;
         got.waypoint_now = rsp_bus.waypoint_now;
         got.arrived = rsp_bus.arrived;
         got.land_request = rsp_bus.land_request;
         got.done_res = rsp_bus.done_res;
         sb.check_command(got);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("waypoint_pi_position_follower_top regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Transaction builders
   // ---------------------------------------------------------------------------------

   // Load: position and time fields are don't-care, so fill them with noise.
   function automatic follow_req_type load_item(logic [SLOT_W-1:0] s, logic [CELL_W-1:0] gx,
                                                logic [CELL_W-1:0] gy);
      follow_req_type r;
      r.command = CMD_LOAD;
      r.slot = s;
      r.grid_x = gx;
      r.grid_y = gy;
      r.pos_x = POS_W'($urandom);
      r.pos_y = POS_W'($urandom);
      r.time_ms = $urandom;
      return r;
   endfunction

   // Tick at an explicit position; slot and grid are ignored by a tick.
   function automatic follow_req_type raw_tick(logic signed [POS_W-1:0] px,
                                               logic signed [POS_W-1:0] py,
                                               logic [TIME_W-1:0] t);
      follow_req_type r;
      r.command = CMD_TICK;
      r.slot = SLOT_W'($urandom);
      r.grid_x = CELL_W'($urandom);
      r.grid_y = CELL_W'($urandom);
      r.pos_x = px;
      r.pos_y = py;
      r.time_ms = t;
      return r;
   endfunction

   // Tick placed so that the tracking error equals (ex, ey) against the current target.
   function automatic follow_req_type aimed_tick(int ex, int ey, logic [TIME_W-1:0] t);
      int tx, ty;
      sb.aim_now(tx, ty);
      return raw_tick(POS_W'(tx - ex), POS_W'(ty - ey), t);
   endfunction

   // Tick inside the near band. The time stamp is chosen against the dwell window so
   // that arrivals happen only when wanted: the path may complete only in the last phase.
   function automatic follow_req_type near_tick(int lo, int hi);
      int ex, ey;
      bit go;
      logic [TIME_W-1:0] t;
      ex = lo + int'($urandom_range(0, hi - lo));
      ey = lo + int'($urandom_range(0, hi - lo));
      go = (last_phase || int'(sb.leg) + 1 < sb.eff_len())
           && $urandom_range(0, last_phase ? 3 : 24) == 0;
      if (go) t = sb.settle_start + TIME_W'(sb.dwell) + 32'd1 + $urandom_range(0, 2000);
      else t = sb.settle_start + $urandom_range(0, int'(sb.dwell));
      // now and then the Y axis drifts out of the band while X holds
      if ($urandom_range(0, 14) == 0)
         ey = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(10, 40));
      return aimed_tick(ex, ey, t);
   endfunction

   // Random load; the home cell is favored so the home offset path is hit often.
   function automatic follow_req_type random_load();
      if ($urandom_range(0, 4) == 0) return load_item(SLOT_W'($urandom), '0, '0);
      return load_item(SLOT_W'($urandom), CELL_W'($urandom), CELL_W'($urandom));
   endfunction

   // Mostly runs of near-target ticks (so integrals build up, clamp and dwell runs out),
   // mixed with waypoint reloads and full-range noise ticks.
   function automatic follow_req_type next_item();
      int pick;
      if (run_left > 0) begin
         run_left--;
         if ($urandom_range(0, 9) == 0) return random_load();
         return near_tick(bias_lo, bias_hi);
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) return random_load();
      if (pick < 45) return raw_tick(POS_W'($urandom), POS_W'($urandom), $urandom);
      run_left = $urandom_range(2, 40);
      case ($urandom_range(0, 2))
         0: begin
            bias_lo = -9;
            bias_hi = 9;
         end
         1: begin
            bias_lo = 2;
            bias_hi = 9;
         end
         default: begin
            bias_lo = -9;
            bias_hi = -2;
         end
      endcase
      return near_tick(bias_lo, bias_hi);
   endfunction

   // ---------------------------------------------------------------------------------
   // Drivers (entered and left at a falling edge)
   // ---------------------------------------------------------------------------------

   task automatic send_item(follow_req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= r.command;
      req_bus.slot <= r.slot;
      req_bus.grid_x <= r.grid_x;
      req_bus.grid_y <= r.grid_y;
      req_bus.pos_x <= r.pos_x;
      req_bus.pos_y <= r.pos_y;
      req_bus.time_ms <= r.time_ms;
      do @(posedge clock); while (!req_bus.ready);
      // the transaction is accepted here: predict it before the next one is built
      sb.note_request(r);
      @(negedge clock);
   endtask

   // Stop sending and wait until every predicted response has been seen.
   task automatic settle_queue();
      req_bus.valid <= 1'b0;
      while (sb.expected_cmds.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Leaves csr_we high; the caller drops it after the last write.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.set_reg(idx, v);
      @(negedge clock);
   endtask

   task automatic apply_setup(logic [CSR_DATA_W-1:0] kp, logic [CSR_DATA_W-1:0] ki,
                              logic [CSR_DATA_W-1:0] dwell, logic [CSR_DATA_W-1:0] cell_sz,
                              logic [CSR_DATA_W-1:0] ox, logic [CSR_DATA_W-1:0] oy,
                              logic [CSR_DATA_W-1:0] home, logic [CSR_DATA_W-1:0] plen);
      write_reg(REG_KP, kp);
      write_reg(REG_KI, ki);
      write_reg(REG_DWELL, dwell);
      write_reg(REG_CELL_SIZE, cell_sz);
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_HOME_OFFSET, home);
      write_reg(REG_PATH_LENGTH, plen);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(int n, bit hold_midway);
      for (int i = 0; i < n; i++) begin
         // one full drain partway through, with the sender holding off
         if (hold_midway && i == n / 2) settle_queue();
         send_item(next_item());
      end
   endtask

   // Directed opening: fill the whole table (home cell and grid extremes first), then
   // ticks at the position extremes, across the time wrap, at the edge of the near
   // band, and one that just outlasts the default dwell so the path advances.
   task automatic run_directed();
      send_item(load_item(SLOT_W'(0), CELL_W'(0), CELL_W'(0)));
      send_item(load_item(SLOT_W'(1), CELL_W'(15), CELL_W'(15)));
      send_item(load_item(SLOT_W'(2), CELL_W'(0), CELL_W'(15)));
      send_item(load_item(SLOT_W'(3), CELL_W'(15), CELL_W'(0)));
      for (int s = 4; s < MAX_WAYPOINTS_DEF; s++)
         send_item(load_item(SLOT_W'(s), CELL_W'($urandom), CELL_W'($urandom)));
      send_item(raw_tick(16'sh8000, 16'sh8000, 32'hFFFF_FFF0));
      send_item(aimed_tick(0, 0, 32'h0000_0010));    // near, dwell not yet over (wrapped)
      send_item(aimed_tick(9, -9, 32'h0000_0050));   // 96 ms held
      send_item(aimed_tick(-9, 9, 32'h0000_0055));   // 101 ms held: arrival
      send_item(raw_tick(16'sh7FFF, 16'sh7FFF, 32'h0000_0000));
      send_item(raw_tick(16'sh0000, 16'sh0000, 32'hFFFF_FFFF));
      send_item(aimed_tick(10, 0, 32'h1234_5678));   // X just outside the band
      send_item(aimed_tick(0, -10, 32'h1234_5679));  // Y just outside the band
      send_item(aimed_tick(9, 9, $urandom));
   endtask

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------
   initial begin
      sb = new();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_LOAD;
      req_bus.slot = '0;
      req_bus.grid_x = '0;
      req_bus.grid_y = '0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.time_ms = '0;
      rsp_bus.ready = 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 53;
      last_phase = 1'b0;
      run_left = 0;
      bias_lo = -9;
      bias_hi = 9;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset configuration, light sender gaps, heavy receiver stalls.
      run_directed();
      settle_queue();

      // Extreme gains, zero dwell, widest cells, in-range maximum path length.
      apply_setup(16'h7FFF, 16'h8000, 16'd0, 16'd255, 16'd255, 16'd0, 16'd255, 16'd16);
      run_random(140, 1'b0);
      settle_queue();

      // Swap idling: heavy sender gaps, light receiver stalls.
      send_idle_pct = 53;
      recv_idle_pct = 11;

      // Opposite gain extremes, longest dwell, cell size zero, path length over range.
      apply_setup(16'h8000, 16'h7FFF, 16'hFFFF, 16'd0, 16'd0, 16'd255, 16'd0, 16'd31);
      run_random(140, 1'b0);
      settle_queue();

      // Cell size one, random gains and offsets, path length just over range.
      apply_setup(16'($urandom), 16'($urandom), 16'($urandom_range(0, 50)), 16'd1,
                  16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                  16'($urandom_range(0, 255)), 16'd17);
      run_random(140, 1'b1);
      settle_queue();

      // No idling from here on.
      send_idle_pct = 0;
      recv_idle_pct = 0;

      // Fully random values with junk in the unused upper CSR bits; path length of zero,
      // which saturates to one, so no arrival is steered here.
      apply_setup(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), {11'($urandom), 5'd0});
      run_random(140, 1'b0);
      settle_queue();

      // Closing phase: path length one, so the next arrival finishes the path; ticks
      // and loads after that run against the done state.
      last_phase = 1'b1;
      apply_setup(16'($urandom), 16'($urandom), 16'd5, 16'd2,
                  16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                  16'($urandom_range(0, 255)), 16'd1);
      run_random(110, 1'b0);
      settle_queue();

      repeat (10) @(posedge clock);
      if (sb.fail_count == 0 && sb.expected_cmds.size() == 0) begin
         $display("waypoint_pi_position_follower_top regression: pass");
      end else begin
         $display("waypoint_pi_position_follower_top regression: fail");
      end
      $finish;
   end

endmodule
